@@ rtl/rawt_pkg.sv @@
// shared types and constants for the ack window tracker
`default_nettype none
package rawt_pkg;
  localparam int WinDepth = 32;
  localparam int IdxW = $clog2(WinDepth);
  localparam int CntW = IdxW + 1;
  localparam int SeqW = 10;
  localparam int NumW = 11;
  localparam int TimeW = 48;
  localparam int IvlW = 16;
  localparam logic [NumW-1:0] SeqMod = 11'd1024;
  localparam logic [IvlW-1:0] IvlReset = 16'd200;

  localparam logic [1:0] ACT_SEND = 2'd0;
  localparam logic [1:0] ACT_ACK = 2'd1;
  localparam logic [1:0] ACT_SYNC = 2'd2;
  localparam logic [1:0] ACT_TICK = 2'd3;

  // classified request handed from front to back
  typedef struct packed {
    logic [1:0] action;
    logic [NumW-1:0] num;
    logic [TimeW-1:0] now;
  } req_t;

  typedef struct packed {
    logic [1:0] kind;
    logic ok;
    logic [SeqW-1:0] seq;
    logic last;
  } res_t;
endpackage
`default_nettype wire

@@ rtl/reliable_ack_window_tracker.sv @@
// top level of the reliable ack window tracker
// One request at a time is executed. Send, ack and sync are answered when
// taken; for a new ack or sync below 1024, a scan for the matching entry and
// a close-up shift behind it follow. A tick walks all pending entries, one
// per cycle unless a resend report or an output stall holds it. A request
// starts only once the result register is free. A two-entry request queue in
// front lets the input side run ahead while the engine or output stalls.
`default_nettype none
module reliable_ack_window_tracker (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic cfg_we,
  input  wire logic [15:0] cfg_wdata,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire logic [1:0] in_action,
  input  wire logic [10:0] in_seq_index,
  input  wire logic [47:0] in_now_ms,
  output logic out_valid,
  input  wire logic out_ready,
  output logic [1:0] out_kind,
  output logic out_ok,
  output logic [9:0] out_seq_out,
  output logic out_last
);
  logic q_valid, q_take;
  rawt_pkg::req_t q_req;

  // front: request queue
  rawt_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_action, .in_seq_index, .in_now_ms,
    .q_valid, .q_req, .q_take
  );

  // back: window state and result register
  rawt_back u_back (
    .clk, .rst_n, .cfg_we, .cfg_wdata, .q_valid, .q_req, .q_take,
    .out_valid, .out_ready, .out_kind, .out_ok, .out_seq_out, .out_last
  );
endmodule
`default_nettype wire

@@ rtl/rawt_front.sv @@
// input stage: two-entry request queue decoupling the port from the engine
`default_nettype none
module rawt_front (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire logic [1:0] in_action,
  input  wire logic [10:0] in_seq_index,
  input  wire logic [47:0] in_now_ms,
  output logic q_valid,
  output rawt_pkg::req_t q_req,
  input  wire logic q_take
);
  rawt_pkg::req_t buf_r [2];
  logic rd_r, rd_nxt, wr_r, wr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic push, pop;

  assign in_ready = (cnt_r != 2'd2);
  assign push = in_valid && in_ready;
  assign q_valid = (cnt_r != 2'd0);
  assign pop = q_valid && q_take;
  assign q_req = buf_r[rd_r];

  always_comb begin
    rd_nxt = rd_r ^ pop;
    wr_nxt = wr_r ^ push;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r <= 1'b0;
      wr_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      rd_r <= rd_nxt;
      wr_r <= wr_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      buf_r[wr_r] <= '{action: in_action, num: in_seq_index, now: in_now_ms};
    end
  end
endmodule
`default_nettype wire

@@ rtl/rawt_back.sv @@
// execution engine: pending window, ack matching, resend scan, output register
`default_nettype none
module rawt_back (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic cfg_we,
  input  wire logic [15:0] cfg_wdata,
  input  wire logic q_valid,
  input  rawt_pkg::req_t q_req,
  output logic q_take,
  output logic out_valid,
  input  wire logic out_ready,
  output logic [1:0] out_kind,
  output logic out_ok,
  output logic [9:0] out_seq_out,
  output logic out_last
);
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_FIND = 3'd1;
  localparam logic [2:0] ST_SHIFT = 3'd2;
  localparam logic [2:0] ST_TICK = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  logic [2:0] st_r, st_nxt;
  logic [rawt_pkg::IvlW-1:0] ivl_r;
  logic [rawt_pkg::SeqW-1:0] nseq_r;
  logic [rawt_pkg::NumW-1:0] mark_r;
  logic [rawt_pkg::CntW-1:0] cnt_r;
  logic [rawt_pkg::SeqW-1:0] pseq_r [rawt_pkg::WinDepth];
  logic [rawt_pkg::TimeW-1:0] ptime_r [rawt_pkg::WinDepth];
  logic [rawt_pkg::CntW-1:0] i_r;
  rawt_pkg::req_t cur_r;
  logic any_r;
  logic ov_r, ov_nxt;
  rawt_pkg::res_t res_r;

  logic [rawt_pkg::IdxW-1:0] idx;
  logic [rawt_pkg::NumW-1:0] d_fwd;
  logic [rawt_pkg::NumW:0] num_up, d_wrap;
  logic fresh;
  logic [rawt_pkg::TimeW:0] due;
  logic stale;
  logic out_free;

  assign idx = i_r[rawt_pkg::IdxW-1:0];
  assign out_free = !ov_r || out_ready;
  assign out_valid = ov_r;
  assign out_kind = res_r.kind;
  assign out_ok = res_r.ok;
  assign out_seq_out = res_r.seq;
  assign out_last = res_r.last;

  // window check on the queue head request: 1..31 ahead, direct or wrapped
  always_comb begin
    d_fwd = q_req.num - mark_r;
    num_up = {1'b0, rawt_pkg::SeqMod} + {1'b0, q_req.num};
    d_wrap = num_up - {1'b0, mark_r};
    fresh = (q_req.num != mark_r) &&
            (((q_req.num > mark_r) && (d_fwd < rawt_pkg::NumW'(rawt_pkg::WinDepth))) ||
             ((num_up > {1'b0, mark_r}) &&
              (d_wrap < (rawt_pkg::NumW+1)'(rawt_pkg::WinDepth))));
    due = {1'b0, ptime_r[idx]} + {{(rawt_pkg::TimeW-rawt_pkg::IvlW+1){1'b0}}, ivl_r};
    stale = {1'b0, cur_r.now} > due;
  end

  assign q_take = (st_r == ST_IDLE) && out_free && q_valid;

  // result register load points: answers, quiet tick, held resend report
  always_comb begin
    ov_nxt = ov_r && !out_ready;
    if (q_take && (q_req.action != rawt_pkg::ACT_TICK)) ov_nxt = 1'b1;
    if ((st_r == ST_TICK) && (i_r >= cnt_r) && !any_r && out_free) ov_nxt = 1'b1;
    if ((st_r == ST_EMIT) && out_free && ((i_r >= cnt_r) || stale)) ov_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      ivl_r <= rawt_pkg::IvlReset;
      nseq_r <= rawt_pkg::SeqW'(1);
      mark_r <= '0;
      cnt_r <= '0;
      ov_r <= 1'b0;
    end else begin
      if (cfg_we) ivl_r <= cfg_wdata;
      ov_r <= ov_nxt;
      case (st_r)
        ST_IDLE: begin
          if (q_take) begin
            cur_r <= q_req;
            i_r <= '0;
            any_r <= 1'b0;
            case (q_req.action)
              rawt_pkg::ACT_SEND: begin
                if (cnt_r == rawt_pkg::CntW'(rawt_pkg::WinDepth)) begin
                  res_r <= '{kind: rawt_pkg::ACT_SEND, ok: 1'b0, seq: '0, last: 1'b1};
                end else begin
                  res_r <= '{kind: rawt_pkg::ACT_SEND, ok: 1'b1, seq: nseq_r, last: 1'b1};
                  pseq_r[cnt_r[rawt_pkg::IdxW-1:0]] <= nseq_r;
                  ptime_r[cnt_r[rawt_pkg::IdxW-1:0]] <= q_req.now;
                  cnt_r <= cnt_r + 1'b1;
                  nseq_r <= (nseq_r == rawt_pkg::SeqW'(rawt_pkg::SeqMod - 1)) ? '0
                            : nseq_r + 1'b1;
                end
              end
              rawt_pkg::ACT_ACK, rawt_pkg::ACT_SYNC: begin
                res_r <= '{kind: q_req.action,
                           ok: fresh || ((q_req.action == rawt_pkg::ACT_SYNC) &&
                                         (q_req.num >= rawt_pkg::SeqMod)),
                           seq: '0, last: 1'b1};
                if (fresh && !((q_req.action == rawt_pkg::ACT_SYNC) &&
                               (q_req.num >= rawt_pkg::SeqMod))) begin
                  mark_r <= q_req.num;
                  if (q_req.num < rawt_pkg::SeqMod) st_r <= ST_FIND;
                end
              end
              default: st_r <= ST_TICK;
            endcase
          end
        end
        ST_FIND: begin
          if (i_r >= cnt_r) begin
            st_r <= ST_IDLE;
          end else if (pseq_r[idx] == cur_r.num[rawt_pkg::SeqW-1:0]) begin
            st_r <= ST_SHIFT;
          end else begin
            i_r <= i_r + 1'b1;
          end
        end
        ST_SHIFT: begin
          if (i_r + 1'b1 >= cnt_r) begin
            cnt_r <= cnt_r - 1'b1;
            st_r <= ST_IDLE;
          end else begin
            pseq_r[idx] <= pseq_r[idx + 1'b1];
            ptime_r[idx] <= ptime_r[idx + 1'b1];
            i_r <= i_r + 1'b1;
          end
        end
        ST_TICK: begin
          if (i_r >= cnt_r) begin
            if (!any_r) begin
              if (out_free) begin
                res_r <= '{kind: rawt_pkg::ACT_TICK, ok: 1'b0, seq: '0, last: 1'b1};
                st_r <= ST_IDLE;
              end
            end else begin
              st_r <= ST_IDLE;
            end
          end else if (stale) begin
            // wait until the previous report has left the result register
            if (out_free) begin
              ptime_r[idx] <= cur_r.now;
              res_r <= '{kind: rawt_pkg::ACT_TICK, ok: 1'b1, seq: pseq_r[idx], last: 1'b0};
              any_r <= 1'b1;
              i_r <= i_r + 1'b1;
              st_r <= ST_EMIT;
            end
          end else begin
            i_r <= i_r + 1'b1;
          end
        end
        ST_EMIT: begin
          // hold the found report until the next stale entry or the end decides last
          if (i_r >= cnt_r) begin
            if (out_free) begin
              res_r.last <= 1'b1;
              st_r <= ST_IDLE;
            end
          end else if (!stale) begin
            i_r <= i_r + 1'b1;
          end else if (out_free) begin
            st_r <= ST_TICK;
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ rtl/rawt_checker.sv @@
// port-level checks for the ack window tracker
`default_nettype none
module rawt_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [1:0] out_kind,
  input wire logic out_ok,
  input wire logic [9:0] out_seq_out,
  input wire logic out_last
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_seq_out))
    else $error("result dropped under stall");
  a_send_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != rawt_pkg::ACT_TICK |-> out_last)
    else $error("non-tick result without last");
  a_noseq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == rawt_pkg::ACT_ACK || out_kind == rawt_pkg::ACT_SYNC)
    |-> out_seq_out == '0)
    else $error("ack or sync carries a number");
  a_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == rawt_pkg::ACT_TICK && !out_ok |-> out_last)
    else $error("quiet tick not last");
endmodule

bind reliable_ack_window_tracker rawt_checker u_chk (
  .clk, .rst_n, .out_valid, .out_ready, .out_kind, .out_ok, .out_seq_out, .out_last
);
`default_nettype wire

@@ test/tb_top.sv @@
// self-checking testbench for the reliable ack window tracker
module tb_top;
  localparam logic [1:0] KIND_SEND = 2'd0;
  localparam logic [1:0] KIND_ACK = 2'd1;
  localparam logic [1:0] KIND_SYNC = 2'd2;
  localparam logic [1:0] KIND_RESEND = 2'd3;
  localparam int StallLimit = 4000;
  localparam int DrainCycles = 120;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_action = rawt_pkg::ACT_SEND;
  logic [10:0] in_seq_index = '0;
  logic [47:0] in_now_ms = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_kind;
  logic out_ok;
  logic [9:0] out_seq_out;
  logic out_last;

  reliable_ack_window_tracker u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_action(in_action), .in_seq_index(in_seq_index), .in_now_ms(in_now_ms),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_kind(out_kind), .out_ok(out_ok), .out_seq_out(out_seq_out),
    .out_last(out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // own copy of the tracker state
  logic [9:0] win_seq [rawt_pkg::WinDepth];
  logic [47:0] win_time [rawt_pkg::WinDepth];
  int win_cnt;
  logic [9:0] next_seq;
  logic [10:0] ack_mark;
  logic [15:0] resend_ivl;

  rawt_pkg::res_t answers_q [$];   // results still owed by the block
  int errors = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_left = 0;
  logic [47:0] clock_ms = 48'd1000;

  // true when num lies 1..31 ahead of the mark, directly or across the wrap
  function automatic bit ack_is_fresh(input logic [10:0] num);
    int m;
    int n;
    m = ack_mark;
    n = num;
    if (n == m) return 1'b0;
    if (n > m && n - m < rawt_pkg::WinDepth) return 1'b1;
    return (1024 + n > m) && (1024 + n - m < rawt_pkg::WinDepth);
  endfunction

  // take a fresh number: drop the first matching entry, keep order, move mark
  function automatic void take_number(input logic [10:0] num);
    int i;
    int j;
    for (i = 0; i < win_cnt; i++) begin
      if (num < rawt_pkg::SeqMod && win_seq[i] == num[9:0]) begin
        for (j = i; j + 1 < win_cnt; j++) begin
          win_seq[j] = win_seq[j+1];
          win_time[j] = win_time[j+1];
        end
        win_cnt--;
        break;
      end
    end
    ack_mark = num;
  endfunction

  function automatic void owe(input logic [1:0] kind, input logic ok,
                              input logic [9:0] seq, input logic last);
    rawt_pkg::res_t r;
    r.kind = kind;
    r.ok = ok;
    r.seq = seq;
    r.last = last;
    answers_q.insert(answers_q.size(), r);
  endfunction

  // work out the answers to one accepted request
  function automatic void predict_answers(input logic [1:0] act, input logic [10:0] num,
                                          input logic [47:0] now);
    bit fresh;
    int n;
    longint unsigned limit;
    case (act)
      rawt_pkg::ACT_SEND: begin
        if (win_cnt >= rawt_pkg::WinDepth) begin
          owe(KIND_SEND, 1'b0, '0, 1'b1);
        end else begin
          win_seq[win_cnt] = next_seq;
          win_time[win_cnt] = now;
          win_cnt++;
          owe(KIND_SEND, 1'b1, next_seq, 1'b1);
          next_seq = (next_seq == 10'd1023) ? 10'd0 : next_seq + 10'd1;
        end
      end
      rawt_pkg::ACT_ACK: begin
        fresh = ack_is_fresh(num);
        if (fresh) take_number(num);
        owe(KIND_ACK, fresh, '0, 1'b1);
      end
      rawt_pkg::ACT_SYNC: begin
        // unreliable syncs are always reported and leave the state alone
        fresh = (num >= rawt_pkg::SeqMod);
        if (!fresh && ack_is_fresh(num)) begin
          take_number(num);
          fresh = 1'b1;
        end
        owe(KIND_SYNC, fresh, '0, 1'b1);
      end
      default: begin
        n = 0;
        for (int i = 0; i < win_cnt; i++) begin
          limit = longint'(win_time[i]) + longint'(resend_ivl);
          if (longint'(now) > limit) begin
            owe(KIND_RESEND, 1'b1, win_seq[i], 1'b0);
            win_time[i] = now;
            n++;
          end
        end
        if (n == 0) owe(KIND_RESEND, 1'b0, '0, 1'b1);
        else answers_q[answers_q.size()-1].last = 1'b1;
      end
    endcase
  endfunction

  // offer one request, called and returning at a falling edge
  task automatic send_request(input logic [1:0] act, input logic [10:0] num,
                              input logic [47:0] now);
    int gap;
    if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
      gap = $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_seq_index <= num;
    in_now_ms <= now;
    do @(posedge clk); while (!in_ready);
    predict_answers(act, num, now);
    @(negedge clk);
  endtask

  // let everything drain, then write the resend interval
  task automatic set_interval(input logic [15:0] ivl);
    in_valid <= 1'b0;
    wait (answers_q.size() == 0);
    repeat (DrainCycles) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= ivl;
    @(negedge clk);
    cfg_we <= 1'b0;
    resend_ivl = ivl;
  endtask

  // ack the newest entries while they still count as fresh
  task automatic ack_newest();
    while (win_cnt > 0 && ack_is_fresh({1'b0, win_seq[win_cnt-1]}))
      send_request(rawt_pkg::ACT_ACK, {1'b0, win_seq[win_cnt-1]}, clock_ms);
  endtask

  // field extremes, every action and each corner case
  task automatic test_directed();
    send_request(rawt_pkg::ACT_SEND, 11'd0, 48'd0);
    send_request(rawt_pkg::ACT_SEND, 11'd0, 48'd1000);
    send_request(rawt_pkg::ACT_SEND, 11'd0, 48'hFFFF_FFFF_FFFF);
    send_request(rawt_pkg::ACT_TICK, 11'd0, 48'd150);            // quiet tick
    send_request(rawt_pkg::ACT_TICK, 11'd0, 48'd1300);           // first two resent
    send_request(rawt_pkg::ACT_ACK, 11'd2, 48'd0);               // middle removed, order kept
    send_request(rawt_pkg::ACT_ACK, 11'd2, 48'd0);               // repeat
    send_request(rawt_pkg::ACT_ACK, 11'd1, 48'd0);               // behind the mark
    send_request(rawt_pkg::ACT_TICK, 11'd0, 48'd1600);           // entry 1 resent once more
    send_request(rawt_pkg::ACT_SYNC, 11'd3, 48'd0);              // new sync removes entry 3
    send_request(rawt_pkg::ACT_SYNC, 11'd3, 48'd0);
    send_request(rawt_pkg::ACT_SYNC, 11'd1024, 48'd0);           // unreliable sync
    send_request(rawt_pkg::ACT_SYNC, 11'd1025, 48'd0);
    send_request(rawt_pkg::ACT_ACK, 11'd1023, 48'd0);            // behind the mark across the wrap
    send_request(rawt_pkg::ACT_ACK, 11'd30, 48'd0);              // new but not queued
    send_request(rawt_pkg::ACT_ACK, 11'd62, 48'd0);              // exactly the window ahead: old
    send_request(rawt_pkg::ACT_ACK, 11'd60, 48'd0);
    send_request(rawt_pkg::ACT_SYNC, 11'd61, 48'd0);
    send_request(rawt_pkg::ACT_TICK, 11'd0, 48'hFFFF_FFFF_FFFF);
    send_request(rawt_pkg::ACT_ACK, 11'd1, 48'd0);               // stale entry stays
  endtask

  // fill the window, reject one send, resend the due entries, then ack the newest while fresh
  task automatic test_full_window();
    clock_ms = 48'd50_000;
    while (win_cnt < rawt_pkg::WinDepth) send_request(rawt_pkg::ACT_SEND, 11'd0, clock_ms);
    send_request(rawt_pkg::ACT_SEND, 11'd0, clock_ms);
    send_request(rawt_pkg::ACT_TICK, 11'd0, clock_ms);           // equal time is not older
    send_request(rawt_pkg::ACT_TICK, 11'd0, clock_ms + 48'd1);
    ack_newest();
  endtask

  task automatic test_random(input int count);
    logic [1:0] act;
    logic [10:0] num;
    int pick;
    repeat (count) begin
      clock_ms = clock_ms + 48'($urandom_range(0, 300));
      pick = $urandom_range(99);
      act = (pick < 35) ? rawt_pkg::ACT_SEND : (pick < 60) ? rawt_pkg::ACT_ACK :
            (pick < 75) ? rawt_pkg::ACT_SYNC : rawt_pkg::ACT_TICK;
      pick = $urandom_range(99);
      if (pick < 40 && win_cnt > 0)
        num = {1'b0, win_seq[$urandom_range(0, win_cnt-1)]};
      else if (pick < 80)
        num = 11'((int'(ack_mark) + $urandom_range(1, rawt_pkg::WinDepth-1)) % 1024);
      else
        num = 11'($urandom_range(0, 1025));
      send_request(act, num, (pick[0] && pick > 90) ? 48'({$urandom, $urandom}) : clock_ms);
    end
  endtask

  // send and ack the newest entry in turns, then ack one past the mark
  task automatic test_ack_chase();
    int rounds;
    rounds = 3;
    repeat (rounds) begin
      clock_ms = clock_ms + 48'd7;
      send_request(rawt_pkg::ACT_SEND, 11'd0, clock_ms);
      if (win_cnt > 0) send_request(rawt_pkg::ACT_ACK, {1'b0, win_seq[win_cnt-1]}, clock_ms);
      if ($urandom_range(99) < 3) send_request(rawt_pkg::ACT_TICK, 11'd0, clock_ms);
    end
    send_request(rawt_pkg::ACT_ACK, 11'(int'(ack_mark) + 1), clock_ms);
  endtask

  // receiver holds off long enough for the input side to back up
  task automatic test_backpressure();
    hold_left = 400;
    repeat (6) send_request(rawt_pkg::ACT_SEND, 11'd0, clock_ms);
    repeat (6) send_request(rawt_pkg::ACT_TICK, 11'd0, clock_ms + 48'd70_000);
  endtask

  // result channel ready, with an optional long hold-off
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ready <= (rx_idle_pct == 0) || ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // compare each result against the oldest one owed
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (answers_q.size() == 0) begin
        $display("%0t unexpected result kind %0d ok %0d seq %0d last %0d", $time,
                 out_kind, out_ok, out_seq_out, out_last);
        errors++;
      end else begin
        rawt_pkg::res_t e;
        e = answers_q.pop_front();
        if (out_kind !== e.kind) begin
          $display("%0t kind: expected %0d actual %0d", $time, e.kind, out_kind);
          errors++;
        end
        if (out_ok !== e.ok) begin
          $display("%0t ok: expected %0d actual %0d", $time, e.ok, out_ok);
          errors++;
        end
        if (out_seq_out !== e.seq) begin
          $display("%0t seq_out: expected %0d actual %0d", $time, e.seq, out_seq_out);
          errors++;
        end
        if (out_last !== e.last) begin
          $display("%0t last: expected %0d actual %0d", $time, e.last, out_last);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    win_cnt = 0;
    next_seq = 10'd1;
    ack_mark = '0;
    resend_ivl = rawt_pkg::IvlReset;
    for (int i = 0; i < rawt_pkg::WinDepth; i++) begin
      win_seq[i] = '0;
      win_time[i] = '0;
    end
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    tx_idle_pct = 23;
    rx_idle_pct = 64;
    test_directed();
    set_interval(16'd0);
    test_full_window();
    test_random(15);

    tx_idle_pct = 64;
    rx_idle_pct = 23;
    set_interval(16'd65535);
    test_random(8);
    set_interval(16'($urandom_range(1, 400)));
    test_random(8);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_interval(rawt_pkg::IvlReset);
    test_random(9);
    test_ack_chase();
    test_backpressure();

    in_valid <= 1'b0;
    wait (answers_q.size() == 0);
    repeat (DrainCycles) @(posedge clk);
    if (errors == 0 && answers_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

@@ sim.f @@
rtl/rawt_pkg.sv
rtl/rawt_front.sv
rtl/rawt_back.sv
rtl/reliable_ack_window_tracker.sv
rtl/rawt_checker.sv
test/tb_top.sv
